[sv/trpa_pkg.sv]
// Package for the typed resource pool allocator.
// Holds sizes, opcode, status and state codes, and the node entry layout.
// No dependencies.
package trpa_pkg;

    // Pool sizing
    localparam int MAX_NODES = 256;
    localparam int NUM_KINDS = 3;
    localparam int ID_W      = $clog2(MAX_NODES);
    localparam int PTR_W     = ID_W + 1;
    localparam int KIND_W    = 2;

    // Empty stack marker and end of a free list
    localparam logic [PTR_W-1:0] EMPTY_PTR = PTR_W'(MAX_NODES);

    typedef enum logic
    {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        ST_REUSED       = 3'd0,
        ST_NEW          = 3'd1,
        ST_RELEASED     = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_BAD          = 3'd4,
        ST_EXHAUSTED    = 3'd5
    } status_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // One node entry in the node memory
    typedef struct packed
    {
        logic [PTR_W-1:0]  link;
        logic [KIND_W-1:0] kind;
        logic              busy;
    } node_entry_t;

    localparam int ENTRY_W = $bits(node_entry_t);

    // True when a kind code names a real kind
    function automatic logic kind_valid(input logic [KIND_W-1:0] k);
        kind_valid = (k < KIND_W'(NUM_KINDS));
    endfunction

endpackage

[sv/trpa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered and holds while no read is issued.
// No dependencies.
module trpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/typed_resource_pool_allocator_core.sv]
// LIFO free-list pool allocator for nodes of several kinds; request and release
// transactions each give one result transaction. Uses trpa_pkg and trpa_ram.
//
// On acceptance the node memory is read (the kind's stack head for a request, the
// named node for a release); in the update state that follows, the entry is checked,
// written back and the result is loaded into the output register. Because of that
// memory read-then-update loop, no new transaction is accepted until the update of
// the last one is done. A result waiting in the output register does not block the
// next input; the update state waits only if the previous result is still untaken.
// Stack heads and the id counter sit in flip-flops; node links, kinds and busy
// flags sit in one 256-entry memory with no clearing pass after reset.
module typed_resource_pool_allocator_core
    import trpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [KIND_W-1:0] node_kind,
    input  logic [ID_W-1:0]   node_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   granted_id,
    output logic              ok,
    output logic [2:0]        status
);

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg [NUM_KINDS];
    logic [PTR_W-1:0]  nfi_reg, nfi_next;
    logic              op_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;

    logic              out_valid_reg;
    logic [ID_W-1:0]   gid_reg;
    logic              ok_reg;
    status_t           status_reg;

    logic              in_fire, slot_free, exec_fire;
    logic [PTR_W-1:0]  in_head, req_head, rel_head;
    node_entry_t       rd_entry, wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic              mem_we;
    logic [ID_W-1:0]   mem_waddr, mem_raddr;

    logic              head_we;
    logic [KIND_W-1:0] head_wk;
    logic [PTR_W-1:0]  head_wval;
    logic              nfi_inc;
    logic [ID_W-1:0]   res_id;
    logic              res_ok;
    status_t           res_st;

    // Handshake
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign exec_fire = (state_reg == S_EXEC) && slot_free;

    // Stack head selects: input kind, held kind, kind of the released node
    always_comb
    begin
        in_head  = EMPTY_PTR;
        req_head = EMPTY_PTR;
        rel_head = EMPTY_PTR;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            if (node_kind == KIND_W'(k))
            begin
                in_head = head_reg[k];
            end
            if (kind_reg == KIND_W'(k))
            begin
                req_head = head_reg[k];
            end
            if (rd_entry.kind == KIND_W'(k))
            begin
                rel_head = head_reg[k];
            end
        end
    end

    // Read address on acceptance
    assign mem_raddr = (opcode == OP_REQUEST) ? in_head[ID_W-1:0] : node_id;

    trpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_entry),
        .re    (in_fire),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    assign rd_entry = node_entry_t'(rd_data);

    // Update decision for the held transaction
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = id_reg;
        wr_entry  = rd_entry;
        head_we   = 1'b0;
        head_wk   = kind_reg;
        head_wval = EMPTY_PTR;
        nfi_inc   = 1'b0;
        res_id    = '0;
        res_ok    = 1'b0;
        res_st    = ST_BAD;
        if (op_reg == OP_REQUEST)
        begin
            if (!kind_valid(kind_reg))
            begin
                res_st = ST_BAD;
            end
            else if (req_head < EMPTY_PTR)
            begin
                // Pop the kind's top node
                mem_we        = 1'b1;
                mem_waddr     = req_head[ID_W-1:0];
                wr_entry.busy = 1'b1;
                head_we       = 1'b1;
                head_wval     = rd_entry.link;
                res_id        = req_head[ID_W-1:0];
                res_ok        = 1'b1;
                res_st        = ST_REUSED;
            end
            else if (nfi_reg >= EMPTY_PTR)
            begin
                res_st = ST_EXHAUSTED;
            end
            else
            begin
                // Create a fresh node
                mem_we        = 1'b1;
                mem_waddr     = nfi_reg[ID_W-1:0];
                wr_entry.link = EMPTY_PTR;
                wr_entry.kind = kind_reg;
                wr_entry.busy = 1'b1;
                nfi_inc       = 1'b1;
                res_id        = nfi_reg[ID_W-1:0];
                res_ok        = 1'b1;
                res_st        = ST_NEW;
            end
        end
        else
        begin
            if ({1'b0, id_reg} >= nfi_reg)
            begin
                res_st = ST_BAD;
            end
            else if (!rd_entry.busy)
            begin
                res_ok = 1'b1;
                res_st = ST_ALREADY_FREE;
            end
            else if (!kind_valid(rd_entry.kind))
            begin
                res_st = ST_BAD;
            end
            else
            begin
                // Push the node onto its kind's stack
                mem_we        = 1'b1;
                mem_waddr     = id_reg;
                wr_entry.link = rel_head;
                wr_entry.busy = 1'b0;
                head_we       = 1'b1;
                head_wk       = rd_entry.kind;
                head_wval     = {1'b0, id_reg};
                res_ok        = 1'b1;
                res_st        = ST_RELEASED;
            end
        end
        if (!exec_fire)
        begin
            mem_we  = 1'b0;
            head_we = 1'b0;
            nfi_inc = 1'b0;
        end
    end

    assign nfi_next = nfi_inc ? nfi_reg + PTR_W'(1) : nfi_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nfi_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                head_reg[k] <= EMPTY_PTR;
            end
        end
        else
        begin
            state_reg <= state_next;
            nfi_reg   <= nfi_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                if (head_we && (head_wk == KIND_W'(k)))
                begin
                    head_reg[k] <= head_wval;
                end
            end
        end
    end

    // Held transaction and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= opcode;
            kind_reg <= node_kind;
            id_reg   <= node_id;
        end
        if (exec_fire)
        begin
            gid_reg    <= res_id;
            ok_reg     <= res_ok;
            status_reg <= res_st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign granted_id = gid_reg;
    assign ok         = ok_reg;
    assign status     = status_reg;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for typed_resource_pool_allocator_core: directed and random request/release
// traffic, checked against a free-list predictor kept in a scoreboard class.
// Depends on trpa_pkg and the core RTL.
module tb_top;
    import trpa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;

    // Expected fields of one result transaction
    typedef struct
    {
        logic [ID_W-1:0] gid;
        logic            ok;
        status_t         st;
    } grant_t;

    // Free-list predictor plus the queue of grants still owed by the block
    class pool_scoreboard;
        int unsigned       ids_made;
        int unsigned       stack_top [NUM_KINDS];
        int unsigned       below [MAX_NODES];
        logic [KIND_W-1:0] owner_kind [MAX_NODES];
        bit                in_use [MAX_NODES];
        grant_t            owed_grants [$];
        int unsigned       errors;

        function new();
            ids_made = 0;
            errors = 0;
            foreach (stack_top[k])
                stack_top[k] = MAX_NODES;
            foreach (in_use[n])
            begin
                in_use[n] = 1'b0;
                below[n] = MAX_NODES;
                owner_kind[n] = '0;
            end
        endfunction

        // Apply one accepted transaction to the pool and queue its grant
        function void note_transaction(opcode_t op, logic [KIND_W-1:0] kind,
                                       logic [ID_W-1:0] id);
            grant_t      g;
            int unsigned top;
            g = '{gid: '0, ok: 1'b0, st: ST_BAD};
            if (op == OP_REQUEST)
            begin
                if (kind >= NUM_KINDS)
                    g.st = ST_BAD;
                else if (stack_top[kind] < MAX_NODES)
                begin
                    // reuse the most recently freed node of this kind
                    top = stack_top[kind];
                    stack_top[kind] = below[top];
                    in_use[top] = 1'b1;
                    g = '{gid: top[ID_W-1:0], ok: 1'b1, st: ST_REUSED};
                end
                else if (ids_made >= MAX_NODES)
                    g.st = ST_EXHAUSTED;
                else
                begin
                    top = ids_made;
                    ids_made++;
                    owner_kind[top] = kind;
                    in_use[top] = 1'b1;
                    below[top] = MAX_NODES;
                    g = '{gid: top[ID_W-1:0], ok: 1'b1, st: ST_NEW};
                end
            end
            else
            begin
                if (id >= ids_made)
                    g.st = ST_BAD;
                else if (!in_use[id])
                    g = '{gid: '0, ok: 1'b1, st: ST_ALREADY_FREE};
                else
                begin
                    // return it to its own kind's stack
                    in_use[id] = 1'b0;
                    below[id] = stack_top[owner_kind[id]];
                    stack_top[owner_kind[id]] = id;
                    g = '{gid: '0, ok: 1'b1, st: ST_RELEASED};
                end
            end
            owed_grants.insert(owed_grants.size(), g);
        endfunction

        // Compare one result transaction with the oldest owed grant
        function void check_result(logic [ID_W-1:0] gid, logic okv, logic [2:0] st);
            grant_t g;
            if (owed_grants.size() == 0)
            begin
                $error("unexpected result: granted_id %0d ok %0d status %0d", gid, okv, st);
                errors++;
                return;
            end
            g = owed_grants.pop_front();
            if (gid !== g.gid)
            begin
                $error("granted_id: expected %0d, got %0d", g.gid, gid);
                errors++;
            end
            if (okv !== g.ok)
            begin
                $error("ok: expected %0d, got %0d", g.ok, okv);
                errors++;
            end
            if (st !== g.st)
            begin
                $error("status: expected %0d, got %0d", g.st, st);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              opcode;
    logic [KIND_W-1:0] node_kind;
    logic [ID_W-1:0]   node_id;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ID_W-1:0]   granted_id;
    logic              ok;
    logic [2:0]        status;

    pool_scoreboard pool = new();
    int             ready_mode;
    int             stall_left = 0;
    int             cycle_count = 0;

    typed_resource_pool_allocator_core uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .node_kind  (node_kind),
        .node_id    (node_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .granted_id (granted_id),
        .ok         (ok),
        .status     (status)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: check accepted results, then pick next ready per stall mode
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            pool.check_result(granted_id, ok, status);
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 7);
            default:
            begin
                // long stall runs between short open windows
                if (stall_left > 0)
                begin
                    stall_left <= stall_left - 1;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Present one transaction and hold it until accepted; an optional gap follows
    task automatic send_transaction(input opcode_t op, input logic [KIND_W-1:0] kind,
                                    input logic [ID_W-1:0] id, input int gap);
        in_valid <= 1'b1;
        opcode <= op;
        node_kind <= kind;
        node_id <= id;
        do
            @(posedge clk);
        while (!in_ready);
        pool.note_transaction(op, kind, id);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int              req_pct [PHASES];
        int              burst_left;
        int              gap;
        int              pick;
        opcode_t         op;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0] id;

        req_pct = '{85, 50, 30, 90, 60, 20, 95, 40, 70, 25, 80, 55};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_REQUEST;
        node_kind <= '0;
        node_id <= '0;
        ready_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: new nodes, bad kind, release, double release, LIFO reuse, unknown ids
        send_transaction(OP_REQUEST, 2'd0, 8'hFF, 0);
        send_transaction(OP_REQUEST, 2'd1, 8'h00, 0);
        send_transaction(OP_REQUEST, 2'd2, 8'hAA, 0);
        send_transaction(OP_REQUEST, 2'd3, 8'h55, 1);
        send_transaction(OP_RELEASE, 2'd3, 8'd0, 0);
        send_transaction(OP_RELEASE, 2'd0, 8'd0, 0);
        send_transaction(OP_REQUEST, 2'd0, 8'd0, 2);
        send_transaction(OP_RELEASE, 2'd2, 8'd255, 0);
        send_transaction(OP_RELEASE, 2'd1, 8'd3, 0);
        send_transaction(OP_RELEASE, 2'd0, 8'd1, 0);
        send_transaction(OP_RELEASE, 2'd0, 8'd2, 0);
        send_transaction(OP_REQUEST, 2'd2, 8'hFF, 0);
        send_transaction(OP_REQUEST, 2'd1, 8'hFF, 0);
        send_transaction(OP_REQUEST, 2'd1, 8'h0F, 0);
        send_transaction(OP_RELEASE, 2'd1, 8'd3, 0);
        send_transaction(OP_RELEASE, 2'd1, 8'd1, 1);
        send_transaction(OP_REQUEST, 2'd1, 8'hF0, 0);
        send_transaction(OP_REQUEST, 2'd1, 8'hF0, 0);
        send_transaction(OP_RELEASE, 2'd3, 8'd2, 0);
        send_transaction(OP_RELEASE, 2'd3, 8'd0, 0);
        send_transaction(OP_REQUEST, 2'd0, 8'd0, 0);
        send_transaction(OP_REQUEST, 2'd3, 8'd0, 0);

        // Random phases: request mix, sender gaps and receiver stalls change per phase
        burst_left = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            ready_mode = p % 3;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < req_pct[p])
                begin
                    op = OP_REQUEST;
                    kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                    id = 8'($urandom_range(0, 255));
                end
                else
                begin
                    op = OP_RELEASE;
                    kind = 2'($urandom_range(0, 3));
                    pick = $urandom_range(0, 99);
                    if (pick < 10 || pool.ids_made == 0)
                        id = 8'($urandom_range(0, 255));
                    else
                    begin
                        id = 8'($urandom_range(0, pool.ids_made - 1));
                        // mostly aim at nodes that are handed out
                        for (int t = 0; t < 4 && pick < 75 && !pool.in_use[id]; t++)
                            id = 8'($urandom_range(0, pool.ids_made - 1));
                    end
                end
                // bursts of random length, no gaps at all in every fourth phase
                gap = 0;
                if (p % 4 != 3)
                begin
                    if (burst_left == 0)
                    begin
                        gap = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 20);
                    end
                    else
                        burst_left--;
                end
                send_transaction(op, kind, id, gap);
            end
        end
        in_valid <= 1'b0;

        // Drain
        while (pool.owed_grants.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pool.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[sim.f]
sv/trpa_pkg.sv
sv/trpa_ram.sv
sv/typed_resource_pool_allocator_core.sv
verif/tb_top.sv
